[hdl/qte_pkg.sv]
// shared types, constants and arithmetic helpers for the quaternion to euler unit
// no dependencies
package qte_pkg;

   localparam int TERM_W       = 34;
   localparam int VEC_W        = 38;
   localparam int ACC_W        = 34;
   localparam int ROOT_STEPS   = 31;
   localparam int CORDIC_STEPS = 20;

   localparam logic signed [TERM_W-1:0] ONE_Q30 = 34'sd1073741824;
   localparam logic signed [34:0]       SAT_HI  = 35'sd4294967295;
   localparam logic signed [34:0]       SAT_LO  = -35'sd4294967296;
   localparam logic signed [ACC_W-1:0]  DEG90   = 34'sd754974720;
   localparam logic signed [18:0]       ROLL_LIM  = 19'sd23040;
   localparam logic signed [18:0]       PITCH_LIM = 19'sd11520;

   // sine and cosine terms, Q.30
   typedef struct packed {
      logic signed [TERM_W-1:0] sr;
      logic signed [TERM_W-1:0] cr;
      logic signed [TERM_W-1:0] sp;
      logic signed [TERM_W-1:0] sy;
      logic signed [TERM_W-1:0] cy;
   } term_type;

   // item inside the square root pipeline
   typedef struct packed {
      logic signed [TERM_W-1:0] sr;
      logic signed [TERM_W-1:0] cr;
      logic signed [TERM_W-1:0] sy;
      logic signed [TERM_W-1:0] cy;
      logic signed [30:0]       sp;
      logic                     sat_pos;
      logic                     sat_neg;
      logic [60:0]              v;
      logic [61:0]              r;
   } root_type;

   // one cordic vector
   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ACC_W-1:0] acc;
      logic                    zero;
   } vec_type;

   // item inside the cordic pipeline
   typedef struct packed {
      vec_type roll;
      vec_type pitch;
      vec_type yaw;
      logic    sat_pos;
      logic    sat_neg;
   } cord_type;

   // saturate to the 33-bit signed range
   function automatic logic signed [TERM_W-1:0] sat33(input logic signed [34:0] v);
      if (v > SAT_HI) return SAT_HI[TERM_W-1:0];
      if (v < SAT_LO) return SAT_LO[TERM_W-1:0];
      return v[TERM_W-1:0];
   endfunction

   // atan(2^-i) in 2^-23 degree
   function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
      case (i)
         0:  return 34'sd377487360;
         1:  return 34'sd222843801;
         2:  return 34'sd117744544;
         3:  return 34'sd59768969;
         4:  return 34'sd30000467;
         5:  return 34'sd15014858;
         6:  return 34'sd7509261;
         7:  return 34'sd3754860;
         8:  return 34'sd1877459;
         9:  return 34'sd938733;
         10: return 34'sd469367;
         11: return 34'sd234683;
         12: return 34'sd117342;
         13: return 34'sd58671;
         14: return 34'sd29335;
         15: return 34'sd14668;
         16: return 34'sd7334;
         17: return 34'sd3667;
         18: return 34'sd1833;
         19: return 34'sd917;
         default: return '0;
      endcase
   endfunction

   // fold the left half plane into the right one
   function automatic vec_type prerot(input logic signed [VEC_W-1:0] y,
                                      input logic signed [VEC_W-1:0] x);
      vec_type o;
      o.zero = (x == '0) && (y == '0);
      o.x    = x;
      o.y    = y;
      o.acc  = '0;
      if (x < 0) begin
         if (y >= 0) begin
            o.x   = y;
            o.y   = -x;
            o.acc = DEG90;
         end else begin
            o.x   = -y;
            o.y   = x;
            o.acc = -DEG90;
         end
      end
      return o;
   endfunction

   // round to 1/128 degree, half up, then clamp
   function automatic logic signed [18:0] round_clamp(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [18:0] lim);
      logic signed [34:0] s;
      logic signed [18:0] r;
      s = 35'(acc) + 35'sd32768;
      r = 19'(s >>> 16);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

endpackage

[hdl/qte_terms.sv]
// products and saturated sine and cosine terms, two register stages
// depends on qte_pkg
module qte_terms (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [15:0]    quat_x,
   input  logic signed [15:0]    quat_y,
   input  logic signed [15:0]    quat_z,
   input  logic signed [15:0]    quat_w,
   output qte_pkg::term_type     terms
);

   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   qte_pkg::term_type  terms_ff, terms_in;
   logic signed [34:0] s_r, s_xy2, s_p, s_y, s_yz2;

   // stage one: component products
   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= quat_w * quat_x;
         yz_ff <= quat_y * quat_z;
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         wy_ff <= quat_w * quat_y;
         zx_ff <= quat_z * quat_x;
         wz_ff <= quat_w * quat_z;
         xy_ff <= quat_x * quat_y;
         zz_ff <= quat_z * quat_z;
      end
   end

   // stage two: doubled sums with saturation
   always_comb begin
      s_r   = (35'(wx_ff) + 35'(yz_ff)) <<< 1;
      s_xy2 = (35'(xx_ff) + 35'(yy_ff)) <<< 1;
      s_p   = (35'(wy_ff) - 35'(zx_ff)) <<< 1;
      s_y   = (35'(wz_ff) + 35'(xy_ff)) <<< 1;
      s_yz2 = (35'(yy_ff) + 35'(zz_ff)) <<< 1;
      terms_in.sr = qte_pkg::sat33(s_r);
      terms_in.cr = qte_pkg::ONE_Q30 - qte_pkg::sat33(s_xy2);
      terms_in.sp = qte_pkg::sat33(s_p);
      terms_in.sy = qte_pkg::sat33(s_y);
      terms_in.cy = qte_pkg::ONE_Q30 - qte_pkg::sat33(s_yz2);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         terms_ff <= terms_in;
      end
   end

   assign terms = terms_ff;

endmodule

[hdl/qte_root_stage.sv]
// one step of the digit-by-digit integer square root
// depends on qte_pkg
module qte_root_stage #(
   parameter int K = 0
) (
   input  logic               clock,
   input  logic               en,
   input  qte_pkg::root_type  din,
   output qte_pkg::root_type  dout
);

   localparam logic [61:0] BIT = 62'd1 << (2 * K);

   qte_pkg::root_type dout_ff, dout_in;
   logic [61:0]       trial;

   // compare remainder against trial value
   always_comb begin
      dout_in = din;
      trial   = din.r + BIT;
      if ({1'b0, din.v} >= trial) begin
         dout_in.v = din.v - trial[60:0];
         dout_in.r = (din.r >> 1) + BIT;
      end else begin
         dout_in.r = din.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule

[hdl/qte_cordic_stage.sv]
// one vectoring cordic iteration on the roll, pitch and yaw vectors
// depends on qte_pkg
module qte_cordic_stage #(
   parameter int I = 0
) (
   input  logic               clock,
   input  logic               en,
   input  qte_pkg::cord_type  din,
   output qte_pkg::cord_type  dout
);

   localparam logic signed [qte_pkg::ACC_W-1:0] ANGLE = qte_pkg::atan_entry(I);

   qte_pkg::cord_type dout_ff, dout_in;

   function automatic qte_pkg::vec_type step(input qte_pkg::vec_type v);
      qte_pkg::vec_type        o;
      logic signed [qte_pkg::VEC_W-1:0] xs;
      logic signed [qte_pkg::VEC_W-1:0] ys;
      o  = v;
      xs = v.x >>> I;
      ys = v.y >>> I;
      if (v.y > 0) begin
         o.x   = v.x + ys;
         o.y   = v.y - xs;
         o.acc = v.acc + ANGLE;
      end else begin
         o.x   = v.x - ys;
         o.y   = v.y + xs;
         o.acc = v.acc - ANGLE;
      end
      return o;
   endfunction

   // rotate each vector toward the x axis
   always_comb begin
      dout_in       = din;
      dout_in.roll  = step(din.roll);
      dout_in.pitch = step(din.pitch);
      dout_in.yaw   = step(din.yaw);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule

[hdl/quaternion_to_euler_angles_unit.sv]
// the result passes through 56 register stages between request and response
// throughput: one transaction per cycle when not stalled; 31 square root and 20 cordic stages set the depth
// the whole pipeline holds while a result waits unaccepted at the output register
// reset clears all valid bits; no clearing pass, ready right after reset
// depends on qte_pkg, qte_terms, qte_root_stage, qte_cordic_stage
module quaternion_to_euler_angles_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle
);

   localparam int DEPTH = 3 + qte_pkg::ROOT_STEPS + 1 + qte_pkg::CORDIC_STEPS + 1;
   localparam int LAST  = DEPTH - 1;

   logic                 en;
   logic [DEPTH-1:0]     valid_ff, valid_in;
   qte_pkg::term_type    terms;
   qte_pkg::root_type    root_pipe [qte_pkg::ROOT_STEPS+1];
   qte_pkg::root_type    sq_ff, sq_in;
   qte_pkg::cord_type    cord_pipe [qte_pkg::CORDIC_STEPS+1];
   qte_pkg::cord_type    pre_ff, pre_in;
   logic [29:0]          sp_abs;
   logic [59:0]          sp_sq;
   logic signed [15:0]   roll_ff, roll_in, yaw_ff, yaw_in;
   logic signed [14:0]   pitch_ff, pitch_in;
   qte_pkg::cord_type    fin;

   // global stall when the output register is full and not taken
   assign en        = !valid_ff[LAST] || rsp_ready;
   assign req_ready = en;
   assign valid_in  = {valid_ff[LAST-1:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // products and terms
   qte_terms u_terms (
      .clock  (clock),
      .en     (en),
      .quat_x (req_quat_x),
      .quat_y (req_quat_y),
      .quat_z (req_quat_z),
      .quat_w (req_quat_w),
      .terms  (terms)
   );

   // pitch saturation flags and square of the sine term
   always_comb begin
      sp_abs         = terms.sp[qte_pkg::TERM_W-1] ? 30'(-terms.sp) : terms.sp[29:0];
      sp_sq          = sp_abs * sp_abs;
      sq_in.sr       = terms.sr;
      sq_in.cr       = terms.cr;
      sq_in.sy       = terms.sy;
      sq_in.cy       = terms.cy;
      sq_in.sp       = terms.sp[30:0];
      sq_in.sat_pos  = terms.sp >= qte_pkg::ONE_Q30;
      sq_in.sat_neg  = terms.sp <= -qte_pkg::ONE_Q30;
      sq_in.v        = (61'd1 << 60) - 61'(sp_sq);
      sq_in.r        = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_in;
      end
   end

   assign root_pipe[0] = sq_ff;

   // square root pipeline, one result bit per stage
   for (genvar j = 0; j < qte_pkg::ROOT_STEPS; j++) begin : g_root
      qte_root_stage #(.K(qte_pkg::ROOT_STEPS - 1 - j)) u_root (
         .clock (clock),
         .en    (en),
         .din   (root_pipe[j]),
         .dout  (root_pipe[j+1])
      );
   end

   // quadrant folding of the three vectors
   always_comb begin
      pre_in.roll    = qte_pkg::prerot(38'(root_pipe[qte_pkg::ROOT_STEPS].sr),
                                       38'(root_pipe[qte_pkg::ROOT_STEPS].cr));
      pre_in.yaw     = qte_pkg::prerot(38'(root_pipe[qte_pkg::ROOT_STEPS].sy),
                                       38'(root_pipe[qte_pkg::ROOT_STEPS].cy));
      pre_in.pitch   = qte_pkg::prerot(38'(root_pipe[qte_pkg::ROOT_STEPS].sp),
                          {7'd0, root_pipe[qte_pkg::ROOT_STEPS].r[30:0]});
      pre_in.sat_pos = root_pipe[qte_pkg::ROOT_STEPS].sat_pos;
      pre_in.sat_neg = root_pipe[qte_pkg::ROOT_STEPS].sat_neg;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_ff <= pre_in;
      end
   end

   assign cord_pipe[0] = pre_ff;

   // cordic pipeline
   for (genvar i = 0; i < qte_pkg::CORDIC_STEPS; i++) begin : g_cordic
      qte_cordic_stage #(.I(i)) u_cordic (
         .clock (clock),
         .en    (en),
         .din   (cord_pipe[i]),
         .dout  (cord_pipe[i+1])
      );
   end

   // rounding, clamping and special cases
   assign fin = cord_pipe[qte_pkg::CORDIC_STEPS];

   always_comb begin
      roll_in  = fin.roll.zero ? '0 :
                 16'(qte_pkg::round_clamp(fin.roll.acc, qte_pkg::ROLL_LIM));
      yaw_in   = fin.yaw.zero ? '0 :
                 16'(qte_pkg::round_clamp(fin.yaw.acc, qte_pkg::ROLL_LIM));
      if (fin.sat_pos) begin
         pitch_in = 15'(qte_pkg::PITCH_LIM);
      end else if (fin.sat_neg) begin
         pitch_in = 15'(-qte_pkg::PITCH_LIM);
      end else if (fin.pitch.zero) begin
         pitch_in = '0;
      end else begin
         pitch_in = 15'(qte_pkg::round_clamp(fin.pitch.acc, qte_pkg::PITCH_LIM));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
      end
   end

   assign rsp_valid       = valid_ff[LAST];
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;

   // checks
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(valid_ff))
      else $error("pipeline moved during stall");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 15'sd11520 && rsp_pitch_angle >= -15'sd11520))
      else $error("pitch out of range");

   a_roll_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= 16'sd23040 && rsp_roll_angle >= -16'sd23040 &&
                     rsp_yaw_angle <= 16'sd23040 && rsp_yaw_angle >= -16'sd23040))
      else $error("roll or yaw out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
